### rtl/kft_pkg.sv
package kft_pkg;

    localparam int KEY_W           = 32;
    localparam int SLOT_W          = 7;
    localparam int CNT_OUT_W       = 32;
    localparam int DEF_TABLE_DEPTH = 128;
    localparam int DEF_COUNT_BITS  = 32;

endpackage

### rtl/kft_cell.sv
module kft_cell
    import kft_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_W-1:0]      search_key,
    input  logic                  we,
    input  logic [KEY_W-1:0]      wr_key,
    input  logic [COUNT_BITS-1:0] wr_count,
    output logic [KEY_W-1:0]      key_q,
    output logic [COUNT_BITS-1:0] count_q,
    output logic                  match
);

    logic [KEY_W-1:0]      key_reg;
    logic [COUNT_BITS-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            count_reg <= '0;
        end
        else if (we)
        begin
            key_reg   <= wr_key;
            count_reg <= wr_count;
        end
    end

    assign match   = (key_reg == search_key);
    assign key_q   = key_reg;
    assign count_q = count_reg;

endmodule

### rtl/kft_tree.sv
module kft_tree
    import kft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                          clk,
    input  logic [TABLE_DEPTH-1:0]        leaf_hit,
    input  logic [COUNT_BITS-1:0]         leaf_count [TABLE_DEPTH],
    input  logic [KEY_W-1:0]              leaf_key [TABLE_DEPTH],
    output logic                          root_hit,
    output logic [$clog2(TABLE_DEPTH)-1:0] root_idx,
    output logic [COUNT_BITS-1:0]         root_count,
    output logic [KEY_W-1:0]              root_key
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LEAVES = 2 ** IDX_W;

    // heap order: node 1 is the root, leaves sit at LEAVES .. 2*LEAVES-1
    logic                  hit_reg   [1:2*LEAVES-1];
    logic [IDX_W-1:0]      idx_reg   [1:2*LEAVES-1];
    logic [COUNT_BITS-1:0] count_reg [1:2*LEAVES-1];
    logic [KEY_W-1:0]      key_reg   [1:2*LEAVES-1];

    genvar j;
    generate
        for (j = 0; j < LEAVES; j++)
        begin : g_leaf
            if (j < TABLE_DEPTH)
            begin : g_real
                always_ff @(posedge clk)
                begin
                    hit_reg[LEAVES+j]   <= leaf_hit[j];
                    idx_reg[LEAVES+j]   <= IDX_W'(j);
                    count_reg[LEAVES+j] <= leaf_count[j];
                    key_reg[LEAVES+j]   <= leaf_key[j];
                end
            end
            else
            begin : g_pad
                // padding never wins: no hit, count at its ceiling, highest index
                always_ff @(posedge clk)
                begin
                    hit_reg[LEAVES+j]   <= 1'b0;
                    idx_reg[LEAVES+j]   <= IDX_W'(j);
                    count_reg[LEAVES+j] <= '1;
                    key_reg[LEAVES+j]   <= '0;
                end
            end
        end

        for (j = 1; j < LEAVES; j++)
        begin : g_node
            logic take_b;

            // left child holds lower indices, so it wins every tie
            assign take_b = !hit_reg[2*j] &&
                            (hit_reg[2*j+1] || (count_reg[2*j+1] < count_reg[2*j]));

            always_ff @(posedge clk)
            begin
                if (take_b)
                begin
                    hit_reg[j]   <= hit_reg[2*j+1];
                    idx_reg[j]   <= idx_reg[2*j+1];
                    count_reg[j] <= count_reg[2*j+1];
                    key_reg[j]   <= key_reg[2*j+1];
                end
                else
                begin
                    hit_reg[j]   <= hit_reg[2*j];
                    idx_reg[j]   <= idx_reg[2*j];
                    count_reg[j] <= count_reg[2*j];
                    key_reg[j]   <= key_reg[2*j];
                end
            end
        end
    endgenerate

    assign root_hit   = hit_reg[1];
    assign root_idx   = idx_reg[1];
    assign root_count = count_reg[1];
    assign root_key   = key_reg[1];

endmodule

### rtl/key_frequency_table_lfu.sv
// key frequency table with least-frequently-used replacement
//
// input: a transaction is taken at a rising edge where start is high and busy
// is low; key_value is sampled then. busy stays high while the key is searched.
// output: done pulses for one cycle with slot, was_hit, count_after and
// evicted_key; the receiver cannot stall, so results are never held back.
// search: every cell compares its key in parallel, then a registered
// selection tree of log2(TABLE_DEPTH) levels picks the first hit or the
// first least-counted entry; done is registered once the tree root settles,
// and the next start can be taken at the edge ending done.
// a new key is taken only after the last one is done, so the wait between
// keys is set by the depth of the selection tree.
// reset: all cells hold key 0 and count 0, the block is idle with done low.
// a key of 0 thus hits the first entry still holding key 0 after reset.
module key_frequency_table_lfu
    import kft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KEY_W-1:0]     key_value,
    output logic                 done,
    output logic [SLOT_W-1:0]    slot,
    output logic                 was_hit,
    output logic [CNT_OUT_W-1:0] count_after,
    output logic [KEY_W-1:0]     evicted_key
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LEVELS = IDX_W;
    localparam int STEP_W = $clog2(LEVELS + 2);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic                  state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic                  fire;

    logic [TABLE_DEPTH-1:0] cell_match;
    logic [TABLE_DEPTH-1:0] cell_we;
    logic [COUNT_BITS-1:0]  cell_count [TABLE_DEPTH];
    logic [KEY_W-1:0]       cell_key   [TABLE_DEPTH];

    logic                  root_hit;
    logic [IDX_W-1:0]      root_idx;
    logic [COUNT_BITS-1:0] root_count;
    logic [KEY_W-1:0]      root_key;
    logic [COUNT_BITS-1:0] new_count;

    logic [IDX_W+SLOT_W-1:0]          idx_wide;
    logic [COUNT_BITS+CNT_OUT_W-1:0]  count_wide;

    logic                 done_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 hit_out_reg;
    logic [CNT_OUT_W-1:0] count_out_reg;
    logic [KEY_W-1:0]     evict_reg;

    // the root of the tree is settled once leaves and all levels are loaded
    assign fire = (state_reg == ST_SEARCH) && (step_reg == STEP_W'(LEVELS + 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        key_next   = key_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SEARCH;
                    step_next  = '0;
                    key_next   = key_value;
                end
            end
            ST_SEARCH:
            begin
                step_next = step_reg + 1'b1;
                if (fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // saturating increment on a hit, fresh count of one on a replacement
    always_comb
    begin
        if (!root_hit)
            new_count = COUNT_BITS'(1);
        else if (root_count == {COUNT_BITS{1'b1}})
            new_count = root_count;
        else
            new_count = root_count + 1'b1;
    end

    genvar j;
    generate
        for (j = 0; j < TABLE_DEPTH; j++)
        begin : g_cell
            assign cell_we[j] = fire && (root_idx == IDX_W'(j));

            kft_cell #(
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .search_key (key_reg),
                .we         (cell_we[j]),
                .wr_key     (key_reg),
                .wr_count   (new_count),
                .key_q      (cell_key[j]),
                .count_q    (cell_count[j]),
                .match      (cell_match[j])
            );
        end
    endgenerate

    kft_tree #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_tree (
        .clk        (clk),
        .leaf_hit   (cell_match),
        .leaf_count (cell_count),
        .leaf_key   (cell_key),
        .root_hit   (root_hit),
        .root_idx   (root_idx),
        .root_count (root_count),
        .root_key   (root_key)
    );

    assign idx_wide   = {{SLOT_W{1'b0}}, root_idx};
    assign count_wide = {{CNT_OUT_W{1'b0}}, new_count};

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot_reg      <= idx_wide[SLOT_W-1:0];
            hit_out_reg   <= root_hit;
            count_out_reg <= count_wide[CNT_OUT_W-1:0];
            evict_reg     <= root_hit ? '0 : root_key;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign slot        = slot_reg;
    assign was_hit     = hit_out_reg;
    assign count_after = count_out_reg;
    assign evicted_key = evict_reg;

endmodule

### test/key_frequency_table_lfu_checker.sv
`timescale 1ns / 100ps

module key_frequency_table_lfu_checker
    import kft_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [KEY_W-1:0]     key_value,
    input  logic                 done,
    input  logic [SLOT_W-1:0]    slot,
    input  logic                 was_hit,
    input  logic [CNT_OUT_W-1:0] count_after,
    input  logic [KEY_W-1:0]     evicted_key,
    output int                   mismatches,
    output int                   pending,
    output int                   hits,
    output int                   replacements,
    output int                   key_evictions
);

    typedef struct packed
    {
        logic [SLOT_W-1:0]    slot;
        logic                 was_hit;
        logic [CNT_OUT_W-1:0] count_after;
        logic [KEY_W-1:0]     evicted_key;
    } table_update_t;

    logic [KEY_W-1:0]      key_store   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] count_store [TABLE_DEPTH];
    table_update_t         expected_updates [$];
    table_update_t         want;
    table_update_t         upd;

    task automatic report_mismatch(input string field, input logic [KEY_W-1:0] want_val,
                                   input logic [KEY_W-1:0] got_val);
        $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, field, want_val, got_val);
        mismatches++;
    endtask

    // first matching key wins; otherwise the first entry with the lowest count is replaced
    function automatic table_update_t update_frequency_table(input logic [KEY_W-1:0] key);
        table_update_t res;
        int hit_idx;
        int victim;
        hit_idx = -1;
        victim = 0;
        res = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hit_idx < 0 && key_store[i] == key)
                hit_idx = i;
        end
        if (hit_idx >= 0)
        begin
            if (count_store[hit_idx] != '1)
                count_store[hit_idx] = count_store[hit_idx] + 1'b1;
            res.slot        = SLOT_W'(hit_idx);
            res.was_hit     = 1'b1;
            res.count_after = CNT_OUT_W'(count_store[hit_idx]);
        end
        else
        begin
            for (int i = 1; i < TABLE_DEPTH; i++)
            begin
                if (count_store[i] < count_store[victim])
                    victim = i;
            end
            res.evicted_key     = key_store[victim];
            key_store[victim]   = key;
            count_store[victim] = COUNT_BITS'(1);
            res.slot            = SLOT_W'(victim);
            res.was_hit         = 1'b0;
            res.count_after     = CNT_OUT_W'(count_store[victim]);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                key_store[i]   = '0;
                count_store[i] = '0;
            end
            expected_updates.delete();
            mismatches    = 0;
            pending       = 0;
            hits          = 0;
            replacements  = 0;
            key_evictions = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_updates.size() == 0)
                    report_mismatch("result with no transaction pending, slot", '0,
                                    KEY_W'(slot));
                else
                begin
                    want = expected_updates.pop_front();
                    if (slot !== want.slot)
                        report_mismatch("slot", KEY_W'(want.slot), KEY_W'(slot));
                    if (was_hit !== want.was_hit)
                        report_mismatch("was_hit", KEY_W'(want.was_hit), KEY_W'(was_hit));
                    if (count_after !== want.count_after)
                        report_mismatch("count_after", KEY_W'(want.count_after),
                                        KEY_W'(count_after));
                    if (evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", want.evicted_key, evicted_key);
                end
            end
            if (start && !busy)
            begin
                upd = update_frequency_table(key_value);
                expected_updates.push_back(upd);
                if (upd.was_hit)
                    hits++;
                else
                begin
                    replacements++;
                    if (upd.evicted_key != '0)
                        key_evictions++;
                end
            end
            pending = expected_updates.size();
        end
    end

endmodule

### test/tb_key_frequency_table_lfu.sv
`timescale 1ns / 100ps

module tb_key_frequency_table_lfu;
    import kft_pkg::*;

    localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
    localparam int COUNT_BITS   = DEF_COUNT_BITS;
    localparam int RANDOM_KEYS  = 1700;
    localparam int POOL_SIZE    = 180;
    localparam int HOT_KEYS     = 16;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KEY_W-1:0]     key_value = '0;
    logic                 done;
    logic [SLOT_W-1:0]    slot;
    logic                 was_hit;
    logic [CNT_OUT_W-1:0] count_after;
    logic [KEY_W-1:0]     evicted_key;

    int mismatches;
    int pending;
    int hits;
    int replacements;
    int key_evictions;
    int stall_cycles = 0;

    logic                 key_taken = 1'b0;
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];
    logic [KEY_W-1:0]     directed_keys [] = '{
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF,
        32'hFFFF_FFFE, 32'h0000_0001, 32'hC0A8_0001, 32'h0A00_0001, 32'hC0A8_0001,
        32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    key_frequency_table_lfu #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .key_value   (key_value),
        .done        (done),
        .slot        (slot),
        .was_hit     (was_hit),
        .count_after (count_after),
        .evicted_key (evicted_key)
    );

    key_frequency_table_lfu_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .key_value     (key_value),
        .done          (done),
        .slot          (slot),
        .was_hit       (was_hit),
        .count_after   (count_after),
        .evicted_key   (evicted_key),
        .mismatches    (mismatches),
        .pending       (pending),
        .hits          (hits),
        .replacements  (replacements),
        .key_evictions (key_evictions)
    );

    // sampled at the edge, read by the sender at the following falling edge
    always @(posedge clk)
        key_taken <= start && !busy;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] key, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            // the block must ignore the key while start is low
            start     <= 1'b0;
            key_value <= $urandom;
            @(negedge clk);
        end
        start     <= 1'b1;
        key_value <= key;
        @(negedge clk);
        while (!key_taken)
            @(negedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // hot keys pile up counts, the warm set is larger than the table and churns
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return key_pool[$urandom_range(HOT_KEYS - 1)];
        else if (r < 80)
            return key_pool[$urandom_range(POOL_SIZE - 1, HOT_KEYS)];
        else if (r < 95)
            return $urandom;
        else if (r < 97)
            return '0;
        else if (r < 99)
            return 32'h1 << $urandom_range(KEY_W - 1);
        else
            return ~(32'h1 << $urandom_range(KEY_W - 1));
    endfunction

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_keys[i])
            send_key(directed_keys[i], 0);
        wait_for_results();

        for (int n = 0; n < RANDOM_KEYS; n++)
        begin
            if (n < RANDOM_KEYS / 3)
                send_key(pick_key(), 37);
            else if (n < 2 * RANDOM_KEYS / 3)
                send_key(pick_key(), 86);
            else
                send_key(pick_key(), 0);
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d keys: %0d hits and %0d replacements,", hits + replacements, hits,
                 replacements);
        $display("%0d replacements displaced a nonzero key", key_evictions);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
